// ===== src/assert_macros.svh =====
// Assertion macros used by the stopwatch lap recorder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property violated");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== src/swlr_pkg.sv =====
// Types and constants of the stopwatch lap recorder
`default_nettype none
package swlr_pkg;

	localparam int CENTI_WRAP = 100;
	localparam int SEC_WRAP   = 60;
	localparam int MIN_WRAP   = 100;
	localparam int LAP_DEPTH_DEF = 20;

	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_TOGGLE = 3'd1;
	localparam logic [2:0] ACT_LAP    = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	typedef struct packed {
		logic [2:0] action;
		logic [4:0] lap_index;
	} evt_t;

	typedef struct packed {
		logic [6:0] minutes;
		logic [5:0] seconds;
		logic [6:0] centis;
	} lap_t;

	typedef struct packed {
		logic [6:0] minutes;
		logic [5:0] seconds;
		logic [6:0] centis;
		logic       running;
		logic [4:0] lap_count;
		logic       lap_valid;
		logic [6:0] lap_minutes;
		logic [5:0] lap_seconds;
		logic [6:0] lap_centis;
	} res_t;

endpackage
`default_nettype wire

// ===== src/stopwatch_lap_recorder.sv =====
// Stopwatch with lap store: one event in, one status item out
// Path: an accepted event is registered in s1, then in res. Throughput:
// one event per cycle unless res_ready stalls; the state update and the
// lap store access (one write or one registered read) share a cycle.
// Reset: arst_n clears time, run flag, lap count and valid flags; the
// lap store itself is not cleared, only entries below the count are read.
`default_nettype none
module stopwatch_lap_recorder #(
	parameter int LAP_DEPTH = swlr_pkg::LAP_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           evt_valid,
	output logic                evt_ready,
	input  wire swlr_pkg::evt_t evt,
	output logic                res_valid,
	input  wire logic           res_ready,
	output swlr_pkg::res_t      res
);
`include "assert_macros.svh"

	localparam int AW   = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
	localparam int CW   = $clog2(LAP_DEPTH + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;
	localparam int IW   = (AW > 5) ? AW : 5;

	// architectural state
	logic [6:0]    centi_q, centi_nxt;
	logic [5:0]    sec_q, sec_nxt;
	logic [6:0]    min_q, min_nxt;
	logic          run_q, run_nxt;
	logic [CW-1:0] cnt_q, cnt_nxt;

	swlr_pkg::lap_t mem_q [LAP_DEPTH];

	logic          accept, move;
	logic          wr_en, rd_hit;
	logic [AW-1:0] waddr, raddr;
	logic [IW-1:0] idx_ext;

	logic           valid_s1;
	logic           hit_s1;
	swlr_pkg::res_t base_s1;
	swlr_pkg::lap_t rdata_s1;
	logic           res_valid_q;
	swlr_pkg::res_t res_nxt;
	swlr_pkg::res_t res_q;

	assign move      = valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || move;
	assign accept    = evt_valid && evt_ready;

	assign idx_ext = IW'(evt.lap_index);
	assign raddr   = idx_ext[AW-1:0];
	assign waddr   = cnt_q[AW-1:0];

	always_comb begin
		centi_nxt = centi_q;
		sec_nxt   = sec_q;
		min_nxt   = min_q;
		run_nxt   = run_q;
		cnt_nxt   = cnt_q;
		wr_en     = 1'b0;
		rd_hit    = 1'b0;
		unique case (evt.action)
			swlr_pkg::ACT_TICK: begin
				if (run_q) begin
					if (centi_q == 7'(swlr_pkg::CENTI_WRAP - 1)) begin
						centi_nxt = '0;
						if (sec_q == 6'(swlr_pkg::SEC_WRAP - 1)) begin
							sec_nxt = '0;
							if (min_q == 7'(swlr_pkg::MIN_WRAP - 1))
								min_nxt = '0;
							else
								min_nxt = min_q + 7'd1;
						end else begin
							sec_nxt = sec_q + 6'd1;
						end
					end else begin
						centi_nxt = centi_q + 7'd1;
					end
				end
			end
			swlr_pkg::ACT_TOGGLE: begin
				run_nxt = !run_q;
			end
			swlr_pkg::ACT_LAP: begin
				if (run_q) begin
					if (cnt_q < CW'(LAP_DEPTH)) begin
						wr_en   = 1'b1;
						cnt_nxt = cnt_q + CW'(1);
					end else begin
						// full store: the press wipes all laps
						cnt_nxt = '0;
					end
				end
			end
			swlr_pkg::ACT_CLEAR: begin
				if (!run_q) begin
					centi_nxt = '0;
					sec_nxt   = '0;
					min_nxt   = '0;
					cnt_nxt   = '0;
				end
			end
			swlr_pkg::ACT_READ: begin
				// count never exceeds the depth, so this also bounds the address
				rd_hit = CMPW'(evt.lap_index) < CMPW'(cnt_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centi_q <= '0;
			sec_q   <= '0;
			min_q   <= '0;
			run_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			centi_q <= centi_nxt;
			sec_q   <= sec_nxt;
			min_q   <= min_nxt;
			run_q   <= run_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// lap store: one write or one read per item
	always_ff @(posedge clk) begin
		if (accept && wr_en)
			mem_q[waddr] <= '{minutes: min_q, seconds: sec_q, centis: centi_q};
		if (accept && rd_hit)
			rdata_s1 <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (move)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1  <= rd_hit;
			base_s1 <= '{
				minutes:     min_nxt,
				seconds:     sec_nxt,
				centis:      centi_nxt,
				running:     run_nxt,
				lap_count:   5'(cnt_nxt),
				lap_valid:   rd_hit,
				lap_minutes: '0,
				lap_seconds: '0,
				lap_centis:  '0
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (move)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	always_comb begin
		res_nxt = base_s1;
		if (hit_s1) begin
			res_nxt.lap_minutes = rdata_s1.minutes;
			res_nxt.lap_seconds = rdata_s1.seconds;
			res_nxt.lap_centis  = rdata_s1.centis;
		end
	end

	always_ff @(posedge clk) begin
		if (move)
			res_q <= res_nxt;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CW'(LAP_DEPTH))
	`ASSERT_NEVER(a_centi_range, clk, arst_n, centi_q > 7'(swlr_pkg::CENTI_WRAP - 1))
	`ASSERT_NEVER(a_sec_range, clk, arst_n, sec_q > 6'(swlr_pkg::SEC_WRAP - 1))
	`ASSERT_NEVER(a_min_range, clk, arst_n, min_q > 7'(swlr_pkg::MIN_WRAP - 1))
	`ASSERT_PROP(a_accept_fills_s1, clk, arst_n, accept |=> valid_s1)
	`ASSERT_NEVER(a_miss_zero, clk, arst_n, res_valid && !res.lap_valid && (res_nxt != res_nxt || |res.lap_minutes || |res.lap_seconds || |res.lap_centis))

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the stopwatch lap recorder: random event traffic, live prediction
`default_nettype none
module testbench;

	localparam int LAPS        = swlr_pkg::LAP_DEPTH_DEF;
	localparam int HOLD_CYCLES = 200;
	localparam int IDLE_LIMIT  = 5000;
	localparam int SWEEP_TICKS = 105;
	localparam int RAND_ITEMS  = 450;

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           evt_valid = 1'b0;
	logic           evt_ready;
	swlr_pkg::evt_t evt       = '0;
	logic           res_valid;
	logic           res_ready = 1'b0;
	swlr_pkg::res_t res;

	stopwatch_lap_recorder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// predicted stopwatch state
	logic [6:0]     cur_min   = '0;
	logic [5:0]     cur_sec   = '0;
	logic [6:0]     cur_centi = '0;
	logic           is_running = 1'b0;
	logic [4:0]     lap_total = '0;
	swlr_pkg::lap_t lap_mem [LAPS];

	swlr_pkg::evt_t event_queue [$];
	swlr_pkg::res_t status_expect [$];

	int  errors = 0;
	int  accepted = 0;
	int  checked = 0;
	int  n_items = 0;
	int  read_hits = 0;
	int  full_clears = 0;
	int  minute_wraps = 0;
	int  hold_mark = 32'h7fff_ffff;
	int  send_gap = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  idle = 0;
	bit  hold_done = 0;
	bit  calm = 0;
	bit  gen_run = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic swlr_pkg::res_t step_stopwatch(swlr_pkg::evt_t e);
		swlr_pkg::res_t r;
		r = '0;
		case (e.action)
			swlr_pkg::ACT_TICK: if (is_running) begin
				if (cur_centi == 7'd99) begin
					cur_centi = '0;
					if (cur_sec == 6'd59) begin
						cur_sec = '0;
						if (cur_min == 7'd99) begin
							cur_min = '0;
							minute_wraps++;
						end else
							cur_min = cur_min + 7'd1;
					end else
						cur_sec = cur_sec + 6'd1;
				end else
					cur_centi = cur_centi + 7'd1;
			end
			swlr_pkg::ACT_TOGGLE: is_running = !is_running;
			swlr_pkg::ACT_LAP: if (is_running) begin
				if (lap_total < LAPS) begin
					lap_mem[lap_total] = '{minutes: cur_min, seconds: cur_sec, centis: cur_centi};
					lap_total = lap_total + 5'd1;
				end else begin
					// full store: the press wipes the laps instead
					lap_total = '0;
					full_clears++;
				end
			end
			swlr_pkg::ACT_CLEAR: if (!is_running) begin
				cur_min   = '0;
				cur_sec   = '0;
				cur_centi = '0;
				lap_total = '0;
			end
			swlr_pkg::ACT_READ: if (e.lap_index < lap_total) begin
				r.lap_valid   = 1'b1;
				r.lap_minutes = lap_mem[e.lap_index].minutes;
				r.lap_seconds = lap_mem[e.lap_index].seconds;
				r.lap_centis  = lap_mem[e.lap_index].centis;
				read_hits++;
			end
			default: ;
		endcase
		r.minutes   = cur_min;
		r.seconds   = cur_sec;
		r.centis    = cur_centi;
		r.running   = is_running;
		r.lap_count = lap_total;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid <= 1'b0;
			evt <= '0;
			send_gap <= 0;
		end else if (!evt_valid || evt_ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				evt_valid <= 1'b0;
			end else if (event_queue.size() != 0) begin
				evt <= event_queue.pop_front();
				evt_valid <= 1'b1;
				send_gap <= calm ? 0 : pick_gap();
			end else
				evt_valid <= 1'b0;
		end
	end

	// receiver, with one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (!hold_done && checked >= hold_mark) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			res_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_ready <= 1'b0;
		end else if (calm || $urandom_range(99) < 75)
			res_ready <= 1'b1;
		else begin
			stall_left <= pick_gap();
			res_ready <= 1'b0;
		end
	end

	// monitor: check before predicting so a fresh prediction is never matched early
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (status_expect.size() == 0) begin
					$error("result item with nothing expected");
					errors++;
				end else begin
					swlr_pkg::res_t want;
					want = status_expect.pop_front();
					check_field("minutes", want.minutes, res.minutes);
					check_field("seconds", want.seconds, res.seconds);
					check_field("centis", want.centis, res.centis);
					check_field("running", want.running, res.running);
					check_field("lap_count", want.lap_count, res.lap_count);
					check_field("lap_valid", want.lap_valid, res.lap_valid);
					check_field("lap_minutes", want.lap_minutes, res.lap_minutes);
					check_field("lap_seconds", want.lap_seconds, res.lap_seconds);
					check_field("lap_centis", want.lap_centis, res.lap_centis);
				end
				checked <= checked + 1;
			end
			if (evt_valid && evt_ready) begin
				status_expect.push_back(step_stopwatch(evt));
				accepted <= accepted + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_valid && evt_ready) || (res_valid && res_ready))
				idle <= 0;
			else if (idle >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else
				idle <= idle + 1;
		end
	end

	task automatic add(logic [2:0] act, logic [4:0] idx);
		event_queue.push_back('{action: act, lap_index: idx});
		if (act == swlr_pkg::ACT_TOGGLE)
			gen_run = !gen_run;
		n_items++;
	endtask

	// sampled at the falling edge, after all updates of the rising edge settled
	task automatic drain();
		while (event_queue.size() != 0 || evt_valid || status_expect.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int phase_end;
		int rand_end;
		int phase;
		int r;
		int n;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle-state corners, unused codes, ignored presses
		add(swlr_pkg::ACT_READ, 5'd0);
		add(swlr_pkg::ACT_READ, 5'd31);
		add(swlr_pkg::ACT_TICK, 5'd0);
		add(swlr_pkg::ACT_LAP, 5'd0);
		add(swlr_pkg::ACT_CLEAR, 5'd0);
		add(3'd5, 5'd10);
		add(3'd6, 5'd21);
		add(3'd7, 5'd31);
		add(swlr_pkg::ACT_TOGGLE, 5'd0);
		add(swlr_pkg::ACT_TICK, 5'd0);
		add(swlr_pkg::ACT_TICK, 5'd0);
		add(swlr_pkg::ACT_LAP, 5'd0);
		add(swlr_pkg::ACT_CLEAR, 5'd0);
		add(swlr_pkg::ACT_READ, 5'd0);
		add(swlr_pkg::ACT_READ, 5'd1);
		add(swlr_pkg::ACT_TICK, 5'd0);
		add(swlr_pkg::ACT_LAP, 5'd0);
		add(swlr_pkg::ACT_READ, 5'd1);
		add(swlr_pkg::ACT_TOGGLE, 5'd0);
		add(swlr_pkg::ACT_TICK, 5'd0);
		add(swlr_pkg::ACT_LAP, 5'd0);
		add(swlr_pkg::ACT_READ, 5'd19);
		add(swlr_pkg::ACT_CLEAR, 5'd0);
		add(swlr_pkg::ACT_READ, 5'd0);
		drain();

		// back-to-back ticks across the first seconds rollover
		calm = 1;
		gen_run = is_running;
		if (gen_run)
			add(swlr_pkg::ACT_TOGGLE, 5'd0);
		add(swlr_pkg::ACT_CLEAR, 5'd0);
		add(swlr_pkg::ACT_TOGGLE, 5'd0);
		for (int i = 1; i <= SWEEP_TICKS; i++) begin
			add(swlr_pkg::ACT_TICK, 5'd0);
			if (i == 99) begin
				add(swlr_pkg::ACT_LAP, 5'd0);
				add(swlr_pkg::ACT_READ, 5'd0);
			end
		end
		add(swlr_pkg::ACT_READ, 5'd0);
		add(swlr_pkg::ACT_TOGGLE, 5'd0);
		drain();

		rand_end = n_items + RAND_ITEMS;
		phase = 0;
		while (n_items < rand_end) begin
			calm = (phase % 3 == 2);
			gen_run = is_running;
			if (phase == 1)
				hold_mark = checked + 30;
			phase_end = n_items + 100;
			while (n_items < phase_end) begin
				r = $urandom_range(99);
				if (r < 45) begin
					if (!gen_run)
						add(swlr_pkg::ACT_TOGGLE, 5'd0);
					n = ($urandom_range(1)) ? $urandom_range(24, 18) : $urandom_range(8, 2);
					repeat (n) begin
						if ($urandom_range(99) < 5)
							repeat ($urandom_range(130, 100)) add(swlr_pkg::ACT_TICK, 5'd0);
						else
							repeat ($urandom_range(3)) add(swlr_pkg::ACT_TICK, 5'd0);
						add(swlr_pkg::ACT_LAP, 5'($urandom_range(31)));
						if ($urandom_range(99) < 30)
							add(swlr_pkg::ACT_READ, 5'($urandom_range(23)));
					end
					if ($urandom_range(1))
						add(swlr_pkg::ACT_TOGGLE, 5'd0);
				end else if (r < 65) begin
					repeat ($urandom_range(6, 1))
						add(swlr_pkg::ACT_READ, 5'($urandom_range(31)));
				end else if (r < 80) begin
					if (gen_run)
						add(swlr_pkg::ACT_TOGGLE, 5'd0);
					add(swlr_pkg::ACT_CLEAR, 5'($urandom_range(31)));
					if ($urandom_range(1))
						add(swlr_pkg::ACT_TOGGLE, 5'd0);
				end else begin
					repeat ($urandom_range(5, 1))
						add(3'($urandom_range(7)), 5'($urandom_range(31)));
				end
			end
			drain();
			phase++;
		end

		repeat (8) @(posedge clk);
		$display("Checked %0d results of %0d events, including a tick run across a seconds rollover",
			checked, accepted);
		$display("Lap reads hit: %0d, full-store clears: %0d, minute wraps: %0d",
			read_hits, full_clears, minute_wraps);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
